FILE: sv/xcdr2ser_pkg.sv
// Shared types, constants and codes for the XCDR2 stream serializer.
package xcdr2ser_pkg;

    // Field widths
    localparam int POS_W   = 13;
    localparam int REQ_W   = 3;
    localparam int SIZE_W  = 2;
    localparam int VAL_W   = 64;
    localparam int ID_W    = 28;
    localparam int RIDX_W  = 12;
    localparam int ALIGN_W = 4;
    localparam int WIN_B   = 16;  // two 8-byte words

    // Defaults
    localparam int BUFFER_BYTES_DEF = 4096;
    localparam logic [POS_W-1:0]   CAP_RESET   = 13'd4096;
    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd4;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUT       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BEGIN_LEN = 3'd1;
    localparam logic [REQ_W-1:0] REQ_END_LEN   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MEMBER    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;

    // Register indexes on the APB port
    localparam logic [1:0] REG_CAPACITY   = 2'd0;
    localparam logic [1:0] REG_BIG_ENDIAN = 2'd1;
    localparam logic [1:0] REG_MAX_ALIGN  = 2'd2;

    // Write plan for one item: a two-word byte window plus the new state
    typedef struct packed {
        logic [WIN_B-1:0][7:0] data;
        logic [WIN_B-1:0]      be;
        logic [POS_W-1:0]      base;
        logic [POS_W-1:0]      pos_next;
        logic                  err_next;
    } plan_t;

endpackage

FILE: sv/xcdr2ser_plan.sv
// Request planner: padding, overrun checks, byte order and the two-word write window.
module xcdr2ser_plan
    import xcdr2ser_pkg::*;
(
    input  logic [REQ_W-1:0]   req_type,
    input  logic [SIZE_W-1:0]  size_log2,
    input  logic [VAL_W-1:0]   scalar_value,
    input  logic [POS_W-1:0]   hdr_start,
    input  logic [ID_W-1:0]    mbr_id,
    input  logic               mu_flag,
    input  logic [POS_W-1:0]   pos,
    input  logic               err,
    input  logic [POS_W-1:0]   cap_eff,
    input  logic               big_endian,
    input  logic [ALIGN_W-1:0] align_max,
    output plan_t              plan
);

    // Reorders the first n bytes of v into wire order; bytes from n up are zero
    function automatic logic [63:0] order_bytes(input logic [63:0] v, input logic [3:0] n,
                                                input logic big);
        logic [63:0] r;
        logic [2:0]  k;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            k = big ? 3'(n - 4'd1 - 4'(i)) : 3'(i);
            if (4'(i) < n)
            begin
                r[8*i +: 8] = v[8*k +: 8];
            end
        end
        return r;
    endfunction

    logic [1:0]        lim_log2;
    logic [1:0]        sz_al;
    logic [1:0]        al_log2;
    logic [2:0]        mask;
    logic [2:0]        pad;
    logic [3:0]        dfull;
    logic [POS_W:0]    sum_pad;
    logic [POS_W:0]    sum_half;
    logic [POS_W:0]    sum_all;
    logic              pad_ok;
    logic              half_ok;
    logic              all_ok;
    logic [31:0]       em_word;
    logic [31:0]       len_word;
    logic              is_put;
    logic              is_stream;
    logic [2:0]        pfx;
    logic [3:0]        dcnt;
    logic [63:0]       src;
    logic [POS_W-1:0]  base;
    logic [POS_W-1:0]  pos_next;
    logic              err_next;
    logic [4:0]        lane_rel;
    logic [4:0]        dofs;
    logic [WIN_B-1:0]  be;
    logic [WIN_B-1:0][7:0] wdata;

    // Alignment and overrun arithmetic
    always_comb
    begin
        priority if (align_max >= 4'd8) lim_log2 = 2'd3;
        else if (align_max >= 4'd4)     lim_log2 = 2'd2;
        else if (align_max >= 4'd2)     lim_log2 = 2'd1;
        else                            lim_log2 = 2'd0;

        is_put    = (req_type == REQ_PUT);
        is_stream = is_put || (req_type == REQ_BEGIN_LEN) || (req_type == REQ_MEMBER);
        sz_al     = is_put ? size_log2 : 2'd2;
        al_log2   = (sz_al > lim_log2) ? lim_log2 : sz_al;
        mask      = 3'((4'd1 << al_log2) - 4'd1);
        pad       = (3'd0 - pos[2:0]) & mask;

        if (is_put)
            dfull = 4'd1 << size_log2;
        else if (req_type == REQ_MEMBER)
            dfull = 4'd8;
        else
            dfull = 4'd4;

        sum_pad  = {1'b0, pos} + {11'd0, pad};
        sum_half = sum_pad + 14'd4;
        sum_all  = sum_pad + {10'd0, dfull};
        pad_ok   = sum_pad  <= {1'b0, cap_eff};
        half_ok  = sum_half <= {1'b0, cap_eff};
        all_ok   = sum_all  <= {1'b0, cap_eff};

        // member header: M bit, LC=4, id
        em_word  = {mu_flag, 1'b1, 2'b00, mbr_id};
        len_word = {19'd0, pos - hdr_start};
    end

    // Request decode into prefix zeros, data bytes and new state
    always_comb
    begin
        base     = pos;
        pfx      = 3'd0;
        dcnt     = 4'd0;
        src      = '0;
        pos_next = pos;
        err_next = err;

        if (!err)
        begin
            if (is_stream)
            begin
                if (is_put)
                    src = order_bytes(scalar_value, dfull, big_endian);
                else if (req_type == REQ_MEMBER)
                    src = order_bytes({32'd0, em_word}, 4'd4, big_endian);
                else
                    src = '0;

                if (!pad_ok)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    pfx = pad;
                    if (all_ok)
                    begin
                        dcnt     = dfull;
                        pos_next = sum_all[POS_W-1:0];
                    end
                    else if ((req_type == REQ_MEMBER) && half_ok)
                    begin
                        dcnt     = 4'd4;
                        pos_next = sum_half[POS_W-1:0];
                        err_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = sum_pad[POS_W-1:0];
                        err_next = 1'b1;
                    end
                end
            end
            else if (req_type == REQ_END_LEN)
            begin
                // back-patch: body start must leave room for the header and not pass pos
                if ((hdr_start < 13'd4) || (hdr_start > pos))
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    base = hdr_start - 13'd4;
                    dcnt = 4'd4;
                    src  = order_bytes({32'd0, len_word}, 4'd4, big_endian);
                end
            end
        end
    end

    // Byte lanes of the two-word window starting at the word of base
    always_comb
    begin
        for (int l = 0; l < WIN_B; l++)
        begin
            lane_rel = 5'(l) - {2'b00, base[2:0]};
            dofs     = lane_rel - {2'b00, pfx};
            be[l]    = 1'b0;
            wdata[l] = 8'd0;
            if (5'(l) >= {2'b00, base[2:0]})
            begin
                if (lane_rel < {2'b00, pfx})
                begin
                    be[l] = 1'b1;
                end
                else if (dofs < {1'b0, dcnt})
                begin
                    be[l]    = 1'b1;
                    wdata[l] = src[8*dofs[2:0] +: 8];
                end
            end
        end
    end

    assign plan.data     = wdata;
    assign plan.be       = be;
    assign plan.base     = base;
    assign plan.pos_next = pos_next;
    assign plan.err_next = err_next;

endmodule

FILE: sv/xcdr2_stream_serializer_core.sv
// Top level of the XCDR2 stream serializer: APB registers, control, byte-lane buffer memory.
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+------------------------------
//  request   | req_type size_log2 scalar_value hdr_start ...  | taken when start & !busy
//  result    | status write_position read_data                | one cycle, marked by done
//  config    | psel penable pwrite paddr pwdata prdata pready | APB, pready tied high
//
// After acceptance the low buffer word is written (or the read word fetched), then the
// high word is written while the result shows with done. The next item can be taken at
// the edge that ends the result cycle; the split into low and high word is set by the
// single write port of the 8-byte-wide buffer. The buffer needs no clearing after reset:
// bytes below the write position are always written first. The receiver cannot stall results.
module xcdr2_stream_serializer_core
    import xcdr2ser_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // request
    input  logic               start,
    output logic               busy,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [SIZE_W-1:0]  size_log2,
    input  logic [VAL_W-1:0]   scalar_value,
    input  logic [POS_W-1:0]   hdr_start,
    input  logic [ID_W-1:0]    mbr_id,
    input  logic               mu_flag,
    input  logic [RIDX_W-1:0]  read_index,
    // result
    output logic               done,
    output logic               status,
    output logic [POS_W-1:0]   write_position,
    output logic [7:0]         read_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int WORDS   = (BUFFER_BYTES + 7) / 8;
    localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CAP_LIM = (BUFFER_BYTES > 8191) ? 8191 : BUFFER_BYTES;
    localparam logic [POS_W-1:0] CAP_LIM_L = POS_W'(CAP_LIM);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LO   = 3'b010,
        ST_HI   = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [POS_W-1:0]     cap_reg;
    logic                 big_reg;
    logic [ALIGN_W-1:0]   malign_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 err_reg;
    plan_t                plan;
    logic [WIN_B-1:0][7:0] wdata_reg;
    logic [WIN_B-1:0]     wbe_reg;
    logic [WORD_AW-1:0]   wr_word_reg;
    logic [WORD_AW-1:0]   rd_word_reg;
    logic [2:0]           rd_lane_reg;
    logic                 rd_hit_reg;
    logic [63:0]          mem_q_reg;
    logic [63:0]          mem [0:WORDS-1];
    logic                 accept;
    logic                 cfg_wr;
    logic [POS_W-1:0]     cap_eff;
    logic [WORD_AW+POS_W-1:0] wr_ext;
    logic [WORD_AW+RIDX_W-1:0] rd_ext;
    logic [WORD_AW-1:0]   mem_addr;
    logic [7:0]           mem_be;
    logic [7:0][7:0]      mem_wbytes;

    assign accept = start && !busy;
    assign busy   = (state_reg == ST_LO);
    assign done   = (state_reg == ST_HI);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // APB register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            big_reg    <= 1'b0;
            malign_reg <= ALIGN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_CAPACITY:   cap_reg    <= pwdata[POS_W-1:0];
                REG_BIG_ENDIAN: big_reg    <= pwdata[0];
                REG_MAX_ALIGN:  malign_reg <= pwdata[ALIGN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CAPACITY:   prdata = {19'd0, cap_reg};
            REG_BIG_ENDIAN: prdata = {31'd0, big_reg};
            REG_MAX_ALIGN:  prdata = {28'd0, malign_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // usable capacity is capped by the physical buffer
    assign cap_eff = (cap_reg > CAP_LIM_L) ? CAP_LIM_L : cap_reg;

    xcdr2ser_plan u_plan (
        .req_type        (req_type),
        .size_log2       (size_log2),
        .scalar_value    (scalar_value),
        .hdr_start       (hdr_start),
        .mbr_id          (mbr_id),
        .mu_flag         (mu_flag),
        .pos             (pos_reg),
        .err             (err_reg),
        .cap_eff         (cap_eff),
        .big_endian      (big_reg),
        .align_max       (malign_reg),
        .plan            (plan)
    );

    // Control sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LO;
            ST_LO:   state_next = ST_HI;
            ST_HI:   state_next = accept ? ST_LO : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            err_reg    <= 1'b0;
            wbe_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                pos_reg    <= plan.pos_next;
                err_reg    <= plan.err_next;
                wbe_reg    <= plan.be;
                rd_hit_reg <= (req_type == REQ_READ) && ({1'b0, read_index} < pos_reg);
            end
        end
    end

    // Word indexes of the write window and the read byte
    assign wr_ext = {{WORD_AW{1'b0}}, plan.base} >> 3;
    assign rd_ext = {{WORD_AW{1'b0}}, read_index} >> 3;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wdata_reg   <= plan.data;
            wr_word_reg <= wr_ext[WORD_AW-1:0];
            rd_word_reg <= rd_ext[WORD_AW-1:0];
            rd_lane_reg <= read_index[2:0];
        end
    end

    // Buffer memory: low word in ST_LO, high word in ST_HI
    always_comb
    begin
        if (state_reg == ST_LO)
        begin
            mem_addr   = wr_word_reg;
            mem_be     = wbe_reg[7:0];
            mem_wbytes = wdata_reg[7:0];
        end
        else
        begin
            mem_addr   = wr_word_reg + WORD_AW'(1);
            mem_be     = (state_reg == ST_HI) ? wbe_reg[15:8] : 8'd0;
            mem_wbytes = wdata_reg[15:8];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 8; l++)
        begin
            if (mem_be[l])
            begin
                mem[mem_addr][8*l +: 8] <= mem_wbytes[l];
            end
        end
        if (state_reg == ST_LO)
        begin
            mem_q_reg <= mem[rd_word_reg];
        end
    end

    // Result ports
    assign status         = err_reg;
    assign write_position = pos_reg;
    assign read_data      = rd_hit_reg ? mem_q_reg[8*rd_lane_reg +: 8] : 8'd0;

    // Checks
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("item accepted but buffer write did not start");

    a_busy_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("result strobe missing after write cycle");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(err_reg) |-> err_reg)
        else $error("sticky error cleared");

    a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && err_reg) |=> ((wbe_reg == '0) && $stable(pos_reg)))
        else $error("buffer changed while error was set");

endmodule

FILE: verif/tb_xcdr2_stream_serializer_core.sv
// Self-checking testbench for the XCDR2 serializer core: random requests, APB config, scoreboard.
module tb_xcdr2_stream_serializer_core
    import xcdr2ser_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_BYTES     = BUFFER_BYTES_DEF;
    localparam int ROOM_LIMIT    = BUF_BYTES - 128;  // stop growing the stream past this point
    localparam int SETTLE_CYCLES = 4;                 // settle time after the last result, with margin
    localparam int STALL_LIMIT   = 200;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 125;

    // How an item picks up values that depend on the live stream state
    typedef enum logic [1:0] {FIX_NONE, FIX_CLOSE, FIX_READ_LIVE} fixup_t;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [SIZE_W-1:0] size;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  bstart;
        logic [ID_W-1:0]   id;
        logic              mu;
        logic [RIDX_W-1:0] ridx;
        fixup_t            fix;
    } ser_item_t;

    typedef struct packed {
        logic             status;
        logic [POS_W-1:0] pos;
        logic [7:0]       rdata;
    } ser_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [REQ_W-1:0]  req_type = REQ_PUT;
    logic [SIZE_W-1:0] size_log2 = '0;
    logic [VAL_W-1:0]  scalar_value = '0;
    logic [POS_W-1:0]  hdr_start = '0;
    logic [ID_W-1:0]   mbr_id = '0;
    logic              mu_flag = 1'b0;
    logic [RIDX_W-1:0] read_index = '0;
    logic              done;
    logic              status;
    logic [POS_W-1:0]  write_position;
    logic [7:0]        read_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    xcdr2_stream_serializer_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .size_log2       (size_log2),
        .scalar_value    (scalar_value),
        .hdr_start       (hdr_start),
        .mbr_id          (mbr_id),
        .mu_flag         (mu_flag),
        .read_index      (read_index),
        .done            (done),
        .status          (status),
        .write_position  (write_position),
        .read_data       (read_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of the serializer: stream bytes, position, sticky error, registers
    logic [7:0]       wire_mem [BUF_BYTES];
    int               wr_pos = 0;
    logic             err_flag = 1'b0;
    logic [POS_W-1:0] cfg_capacity = CAP_RESET;
    logic             cfg_big = 1'b0;
    logic [3:0]       cfg_align = ALIGN_RESET;
    logic [POS_W-1:0] open_starts [$];   // body starts of headers not yet patched

    ser_item_t   pending_items [$];
    ser_result_t expected_results [$];
    ser_item_t   live_item;

    int          idle_left = 0;
    int          idle_pct = 25;
    bit          calm = 1'b0;
    bit          guard_room = 1'b0;
    int          items_queued = 0;
    int          items_accepted = 0;
    int          results_checked = 0;
    int          cfg_writes = 0;
    int          fail_count = 0;
    int unsigned stall_cycles = 0;

    int          align_plan [PHASES] = '{8, 1, 2, 0, 15, 5};
    int          pct_plan [PHASES] = '{30, 0, 50, 15, 40, 0};

    function automatic int cap_limit();
        return (int'(cfg_capacity) > BUF_BYTES) ? BUF_BYTES : int'(cfg_capacity);
    endfunction

    function automatic int align_cap();
        if (cfg_align >= 4'd8) return 8;
        if (cfg_align >= 4'd4) return 4;
        if (cfg_align >= 4'd2) return 2;
        return 1;
    endfunction

    // Zero-pad to the capped alignment, then lay down n bytes in wire order
    function automatic bit store_scalar(input logic [63:0] v, input int n);
        int lim;
        int eff;
        int pad;
        int k;
        int i;
        if (err_flag) return 1'b0;
        lim = align_cap();
        eff = (n > lim) ? lim : n;
        pad = (eff - (wr_pos & (eff - 1))) & (eff - 1);
        if (wr_pos + pad > cap_limit()) begin
            err_flag = 1'b1;
            return 1'b0;
        end
        repeat (pad)
        begin
            wire_mem[wr_pos] = 8'h00;
            wr_pos++;
        end
        if (wr_pos + n > cap_limit()) begin
            err_flag = 1'b1;
            return 1'b0;
        end
        for (i = 0; i < n; i++)
        begin
            k = cfg_big ? (n - 1 - i) : i;
            wire_mem[wr_pos] = v[8*k +: 8];
            wr_pos++;
        end
        return 1'b1;
    endfunction

    // Back-patch the 4-byte length word just below the body start
    function automatic void patch_length(input logic [POS_W-1:0] bstart);
        logic [31:0] len;
        int k;
        int i;
        if (err_flag) return;
        if (bstart < 4 || bstart > wr_pos) begin
            err_flag = 1'b1;
            return;
        end
        len = 32'(wr_pos - int'(bstart));
        for (i = 0; i < 4; i++)
        begin
            k = cfg_big ? (3 - i) : i;
            wire_mem[int'(bstart) - 4 + i] = len[8*k +: 8];
        end
    endfunction

    function automatic ser_result_t predict_item(input ser_item_t it);
        ser_result_t res;
        logic [7:0]  byte_out;
        byte_out = 8'h00;
        case (it.req)
            REQ_PUT:
                void'(store_scalar(it.value, 1 << it.size));
            REQ_BEGIN_LEN:
            begin
                if (store_scalar(64'd0, 4))
                    open_starts.push_back(POS_W'(wr_pos));
            end
            REQ_END_LEN:
            begin
                patch_length(it.bstart);
                if (open_starts.size() > 0)
                    void'(open_starts.pop_back());
            end
            REQ_MEMBER:
            begin
                // EMHEADER: M flag, LC=4, 28-bit id, then a length word
                if (store_scalar(64'({it.mu, 3'b100, it.id}), 4))
                    if (store_scalar(64'd0, 4))
                        open_starts.push_back(POS_W'(wr_pos));
            end
            REQ_READ:
                if (it.ridx < wr_pos) byte_out = wire_mem[it.ridx];
            default: ;
        endcase
        res.status = err_flag;
        res.pos    = POS_W'(wr_pos);
        res.rdata  = byte_out;
        return res;
    endfunction

    // Driver: one item per accept, random gaps between items
    always @(posedge clk)
    begin
        ser_item_t nxt;
        bit        taken;
        if (rst_n) begin
            taken = start && !busy;
            if (taken) begin
                expected_results.push_back(predict_item(live_item));
                items_accepted++;
                if (!calm && $urandom_range(1, 100) <= idle_pct)
                    idle_left = $urandom_range(1, 7);
            end
            if (taken || !start) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    // shadow is current here: the previous item was already predicted
                    if (nxt.fix == FIX_CLOSE)
                        nxt.bstart = (open_starts.size() > 0) ?
                                     open_starts[open_starts.size() - 1] : POS_W'(wr_pos);
                    else if (nxt.fix == FIX_READ_LIVE)
                        nxt.ridx = (wr_pos > 0) ? RIDX_W'($urandom_range(0, wr_pos - 1)) : '0;
                    live_item       = nxt;
                    start           <= 1'b1;
                    req_type        <= nxt.req;
                    size_log2       <= nxt.size;
                    scalar_value    <= nxt.value;
                    hdr_start       <= nxt.bstart;
                    mbr_id          <= nxt.id;
                    mu_flag         <= nxt.mu;
                    read_index      <= nxt.ridx;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        ser_result_t want;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding: status %0d write_position %0d %s %0h",
                       status, write_position, "read_data", read_data);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (write_position !== want.pos) begin
                    $error("write_position: expected %0d, got %0d", want.pos, write_position);
                    fail_count++;
                end
                if (read_data !== want.rdata) begin
                    $error("read_data: expected %0h, got %0h", want.rdata, read_data);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Stalled for %0d cycles with %0d results outstanding",
                         stall_cycles, expected_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // APB write: setup then access; register updates at the access edge
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CAPACITY:   cfg_capacity = value[POS_W-1:0];
            REG_BIG_ENDIAN: cfg_big = value[0];
            REG_MAX_ALIGN:  cfg_align = value[3:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Block until no item is pending or in flight, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || start || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic enqueue(input ser_item_t it);
        // near the end of the buffer, turn stream growth into reads
        if (guard_room && wr_pos > ROOM_LIMIT &&
            (it.req == REQ_PUT || it.req == REQ_BEGIN_LEN || it.req == REQ_MEMBER)) begin
            it.req = REQ_READ;
            it.fix = FIX_READ_LIVE;
        end
        while (pending_items.size() >= 2) @(negedge clk);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Random payload everywhere; callers set what the request uses
    function automatic ser_item_t make_item(input logic [REQ_W-1:0] req, input fixup_t fx);
        ser_item_t it;
        it.req    = req;
        it.size   = SIZE_W'($urandom);
        it.value  = {$urandom, $urandom};
        it.bstart = POS_W'($urandom);
        it.id     = ID_W'($urandom);
        it.mu     = 1'($urandom);
        it.ridx   = RIDX_W'($urandom);
        it.fix    = fx;
        return it;
    endfunction

    function automatic ser_item_t put_item();
        ser_item_t it;
        int        pick;
        it = make_item(REQ_PUT, FIX_NONE);
        pick = $urandom_range(0, 9);
        if (pick == 0) it.value = '1;
        else if (pick == 1) it.value = '0;
        return it;
    endfunction

    function automatic ser_item_t open_item();
        ser_item_t it;
        int        pick;
        if ($urandom_range(0, 9) < 4) begin
            it = make_item(REQ_MEMBER, FIX_NONE);
            pick = $urandom_range(0, 9);
            if (pick == 0) it.id = '1;
            else if (pick == 1) it.id = '0;
        end else begin
            it = make_item(REQ_BEGIN_LEN, FIX_NONE);
        end
        return it;
    endfunction

    function automatic ser_item_t noise_item();
        return make_item(REQ_W'($urandom_range(5, 7)), FIX_NONE);
    endfunction

    // One item of header body content
    task automatic flat_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) enqueue(put_item());
        else if (r < 78) enqueue(make_item(REQ_READ, FIX_READ_LIVE));
        else if (r < 86) enqueue(make_item(REQ_READ, FIX_NONE));
        else if (r < 93) enqueue(noise_item());
        else enqueue(make_item(REQ_END_LEN, FIX_CLOSE));  // stray close
    endtask

    task automatic inner_group();
        int n;
        enqueue(open_item());
        n = $urandom_range(0, 4);
        repeat (n) flat_item();
        enqueue(make_item(REQ_END_LEN, FIX_CLOSE));
    endtask

    task automatic outer_group();
        int n;
        enqueue(open_item());
        n = $urandom_range(0, 5);
        repeat (n)
        begin
            if ($urandom_range(0, 4) == 0) inner_group();
            else flat_item();
        end
        // now and then the header is left open
        if ($urandom_range(0, 19) != 0)
            enqueue(make_item(REQ_END_LEN, FIX_CLOSE));
    endtask

    initial
    begin
        ser_item_t it;
        int        ph;
        int        phase_base;
        int        r;
        int        kind;
        int        pad;
        string     ending_name;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every request, nesting, empty bodies, reads in and out
        enqueue(make_item(REQ_READ, FIX_NONE) );  // nothing written yet
        it = put_item(); it.size = 2'd0; it.value = '1; enqueue(it);
        it = put_item(); it.size = 2'd3; it.value = 64'h0123_4567_89AB_CDEF; enqueue(it);
        it = put_item(); it.size = 2'd1; it.value = 64'hFFFF_FFFF_FFFF_A55A; enqueue(it);
        it = put_item(); it.size = 2'd2; it.value = '0; enqueue(it);
        enqueue(make_item(REQ_BEGIN_LEN, FIX_NONE));
        it = put_item(); it.size = 2'd0; it.value = 64'h80; enqueue(it);
        enqueue(make_item(REQ_END_LEN, FIX_CLOSE));
        it = make_item(REQ_MEMBER, FIX_NONE); it.mu = 1'b1; it.id = '1; enqueue(it);
        enqueue(make_item(REQ_END_LEN, FIX_CLOSE));  // empty body
        it = make_item(REQ_MEMBER, FIX_NONE); it.mu = 1'b0; it.id = '0; enqueue(it);
        enqueue(make_item(REQ_BEGIN_LEN, FIX_NONE));
        it = put_item(); it.size = 2'd3; it.value = '1; enqueue(it);
        enqueue(make_item(REQ_END_LEN, FIX_CLOSE));
        enqueue(make_item(REQ_END_LEN, FIX_CLOSE));
        enqueue(make_item(REQ_READ, FIX_READ_LIVE));
        it = make_item(REQ_READ, FIX_NONE); it.ridx = '1; enqueue(it);
        it = make_item(REQ_READ, FIX_NONE); it.ridx = '0; enqueue(it);
        enqueue(make_item(REQ_W'(5), FIX_NONE));
        enqueue(make_item(REQ_W'(6), FIX_NONE));
        enqueue(make_item(REQ_W'(7), FIX_NONE));
        enqueue(make_item(REQ_END_LEN, FIX_CLOSE));  // nothing open: zero length at the tail

        // Random phases, each under its own register setting
        guard_room = 1'b1;
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: cfg_write(REG_CAPACITY, 32'd8191);
                2: cfg_write(REG_CAPACITY, 32'd5000);
                3: cfg_write(REG_CAPACITY, 32'($urandom_range(BUF_BYTES, 8191)));
                default: cfg_write(REG_CAPACITY, 32'(BUF_BYTES));
            endcase
            cfg_write(REG_BIG_ENDIAN, (ph == PHASES - 1) ?
                                      32'($urandom_range(0, 1)) : 32'(ph % 2 == 0));
            cfg_write(REG_MAX_ALIGN, 32'(align_plan[ph]));
            idle_pct = pct_plan[ph];
            calm = (ph == PHASES - 1);
            phase_base = items_queued;
            while (items_queued - phase_base < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 65) outer_group();
                else if (r < 85) enqueue(put_item());
                else if (r < 95) enqueue(make_item(REQ_READ, FIX_READ_LIVE));
                else enqueue(noise_item());
            end
        end

        // Closing: one sticky error, then random requests against it
        wait_idle();
        guard_room = 1'b0;
        kind = $urandom_range(0, 3);
        if (kind <= 1) begin
            cfg_write(REG_MAX_ALIGN, 32'd8);
            if (wr_pos % 8 == 0) begin
                it = put_item(); it.size = 2'd0; enqueue(it);
                wait_idle();
            end
            pad = (8 - wr_pos % 8) % 8;
            cfg_write(REG_CAPACITY, 32'((kind == 0) ? wr_pos + pad - 1 : wr_pos + pad));
            it = put_item(); it.size = 2'd3; enqueue(it);
            ending_name = (kind == 0) ? "padding past capacity" : "data past capacity";
        end else begin
            it = make_item(REQ_END_LEN, FIX_NONE);
            if (kind == 2) begin
                it.bstart = POS_W'($urandom_range(0, 3));
                ending_name = "back-patch below the first header";
            end else begin
                it.bstart = POS_W'($urandom_range(wr_pos + 1, 8191));
                ending_name = "back-patch beyond the write position";
            end
            enqueue(it);
        end
        repeat (20)
        begin
            r = $urandom_range(0, 7);
            enqueue(make_item(REQ_W'(r), (r == REQ_READ && $urandom_range(0, 1) == 1) ?
                                         FIX_READ_LIVE : FIX_NONE));
        end
        wait_idle();
        cfg_write(REG_CAPACITY, 32'd0);
        cfg_write(REG_BIG_ENDIAN, 32'(!cfg_big));
        enqueue(put_item());
        enqueue(open_item());
        enqueue(make_item(REQ_READ, FIX_READ_LIVE));
        enqueue(make_item(REQ_END_LEN, FIX_CLOSE));
        wait_idle();

        $display("Drove %0d items through %0d register writes; %0d results compared,",
                 items_accepted, cfg_writes, results_checked);
        $display("stream reached %0d bytes; run ended on a sticky error from %s.",
                 wr_pos, ending_name);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
